// ===== rtl/xs1024_pkg.sv =====
// Shared types, constants and the state mixing function of the xorshift1024* generator.
package xs1024_pkg;

  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned PTR_W     = 4;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = WORD_W / 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [HALF_W-1:0] half_t;

  // Command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Output multiplier and shift amounts of the 31/11/30 form
  localparam word_t       MULT_CONST = 64'd1181783497276652981;
  localparam int unsigned SHIFT_A    = 31;
  localparam int unsigned SHIFT_B    = 11;
  localparam int unsigned SHIFT_C    = 30;

  // Mixed state word handed from the front to the queue
  typedef struct packed {
    logic  valid;
    word_t mixed;
  } mix_push_t;

  // Combine the word at the pointer (a) with the word after it (b)
  function automatic word_t mix_words(input word_t a, input word_t b);
    word_t bs;
    word_t as_shift;
    bs       = b ^ (b << SHIFT_A);
    bs       = bs ^ (bs >> SHIFT_B);
    as_shift = a ^ (a >> SHIFT_C);
    return as_shift ^ bs;
  endfunction

endpackage

// ===== rtl/xs1024_if.sv =====
// Command and result channel interfaces of the xorshift1024* generator.
interface xs1024_cmd_if import xs1024_pkg::*; ;
  logic  valid;
  logic  ready;
  logic  command;
  ptr_t  word_index;
  word_t word_value;

  modport source (output valid, output command, output word_index, output word_value,
                  input ready);
  modport sink   (input valid, input command, input word_index, input word_value,
                  output ready);
endinterface

interface xs1024_rnd_if import xs1024_pkg::*; ;
  logic  valid;
  logic  ready;
  word_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ===== rtl/xorshift1024_star_generator_core.sv =====
// Top level of the xorshift1024* random generator core.
// One command word is taken per clock while the queue has room: a load writes one of the
// sixteen state words, a draw steps the generator and yields one 64-bit random word. With
// the result side ready the core sustains one draw per clock. A draw's mixed word is written
// into a queue slot at the edge that accepts it, then passes the two-stage multiply by the
// output constant (partial products, then result register) on its way to the result side.
// The state ring is updated at acceptance, so consecutive draws never wait on each other. A
// queue of QUEUE_DEPTH mixed words lets commands keep flowing while the result side stalls;
// the command side drops ready only once that queue is full. All sixteen words must be loaded,
// not all zero, before the first draw; the state words have no reset value.
module xorshift1024_star_generator_core import xs1024_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  xs1024_cmd_if.sink   cmd,
  xs1024_rnd_if.source rnd
);

  mix_push_t push;
  logic      full;
  logic      pop;
  logic      head_valid;
  word_t     head;

  xs1024_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (full),
    .push (push)
  );

  xs1024_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  xs1024_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rnd        (rnd)
  );

endmodule

// ===== rtl/xs1024_front.sv =====
// Front end: accepts command words, keeps the rotating state ring and mixes draws.
module xs1024_front import xs1024_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  xs1024_cmd_if.sink cmd,
  input  logic      full,
  output mix_push_t push
);

  // ring[k] holds state word (ptr + k) mod 16, so a draw reads fixed taps 0 and 1
  word_t ring [NUM_WORDS];
  ptr_t  ptr;
  logic  accept;
  logic  is_draw;
  ptr_t  load_slot;
  word_t mixed;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;
  assign is_draw   = (cmd.command == CMD_DRAW);
  assign load_slot = cmd.word_index - ptr;
  assign mixed     = mix_words(ring[0], ring[1]);

  // Hand every accepted draw to the queue
  assign push.valid = accept && is_draw;
  assign push.mixed = mixed;

  // Advance the pointer on each draw
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (accept && is_draw) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Load one word, or rotate the ring with the mixed word at the new pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!is_draw) begin
        ring[load_slot] <= cmd.word_value;
      end else begin
        ring[0] <= mixed;
        for (int k = 1; k < NUM_WORDS - 1; k++) begin
          ring[k] <= ring[k + 1];
        end
        ring[NUM_WORDS - 1] <= ring[0];
      end
    end
  end

endmodule

// ===== rtl/xs1024_queue.sv =====
// Short FIFO of mixed state words between the front and the back end.
module xs1024_queue import xs1024_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  mix_push_t push,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output word_t     head
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  word_t            slots [DEPTH];
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push    = push.valid;
  assign do_pop     = pop && (count != '0);
  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_idx];

  // Track fill level and both indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_idx <= (wr_idx == IDX_W'(DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (do_pop) begin
        rd_idx <= (rd_idx == IDX_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_idx] <= push.mixed;
    end
  end

endmodule

// ===== rtl/xs1024_back.sv =====
// Back end: two-stage 64-bit multiply by the output constant and the result register.
module xs1024_back import xs1024_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  word_t         head,
  output logic          pop,
  xs1024_rnd_if.source  rnd
);

  localparam half_t C_LO = MULT_CONST[HALF_W-1:0];
  localparam half_t C_HI = MULT_CONST[WORD_W-1:HALF_W];

  logic  s1_valid;
  word_t p0;
  half_t p1;
  half_t p2;
  logic  out_valid;
  word_t out_value;
  logic  advance;
  logic  s1_en;
  half_t x_lo;
  half_t x_hi;
  word_t p0_next;
  half_t p1_next;
  half_t p2_next;
  half_t cross_sum;

  assign advance = !out_valid || rnd.ready;
  assign s1_en   = !s1_valid || advance;
  assign pop     = s1_en;

  // Split the operand; only the low 64 bits of the product are kept
  assign x_lo    = head[HALF_W-1:0];
  assign x_hi    = head[WORD_W-1:HALF_W];
  assign p0_next = WORD_W'(x_lo) * WORD_W'(C_LO);
  assign p1_next = x_hi * C_LO;
  assign p2_next = x_lo * C_HI;

  assign cross_sum = p1 + p2;

  // Stage one: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && head_valid) begin
      p0 <= p0_next;
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  // Stage two: sum into the output register, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_value <= p0 + {cross_sum, {HALF_W{1'b0}}};
    end
  end

  assign rnd.valid        = out_valid;
  assign rnd.random_value = out_value;

endmodule

// ===== rtl/xs1024_checker.sv =====
// Port-level checks of the xorshift1024* core and their binding to the top level.
module xs1024_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value
);

  // Reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result word changed or dropped");

  // A full queue frees a slot in the cycle after the result side is ready
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(out_ready) && !$past(in_ready)) |-> in_ready)
    else $error("command side stayed blocked while results drained");

  // A blocked command side means results are backed up
  assert property (@(posedge clk) disable iff (rst)
    (!in_ready && in_valid) |-> out_valid)
    else $error("command side blocked with no result pending");

endmodule

bind xorshift1024_star_generator_core xs1024_checker u_xs1024_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (rnd.valid),
  .out_ready (rnd.ready),
  .out_value (rnd.random_value)
);

// ===== tb/xorshift1024_star_generator_core_tb.sv =====
// Self-checking testbench for the xorshift1024* generator core: predicted draws vs. result words.
`timescale 1ns / 100ps

module xorshift1024_star_generator_core_tb;
  import xs1024_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic  command;
    ptr_t  word_index;
    word_t word_value;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst;

  xs1024_cmd_if cmd_ch ();
  xs1024_rnd_if rnd_ch ();

  xorshift1024_star_generator_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rnd (rnd_ch)
  );

  // Shadow generator state
  word_t gen_words [NUM_WORDS];
  ptr_t  gen_ptr;

  cmd_word_t   pending_cmds [$];
  word_t       expected_randoms [$];

  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned loads_taken;
  int unsigned draws_taken;
  int unsigned randoms_checked;
  int unsigned reseeds;
  int unsigned cmd_words_accepted;
  bit          cmd_taken;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned hold_left;
  bit          hold_done;
  logic        calm_stretch;

  // Run without any idling on every fourth stretch of 128 words
  assign calm_stretch = (cmd_words_accepted[8:7] == 2'b11);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic push_load(input ptr_t idx, input word_t value);
    cmd_word_t w;
    w.command    = CMD_LOAD;
    w.word_index = idx;
    w.word_value = value;
    pending_cmds.push_back(w);
  endtask

  // Index and value of a draw are don't-care, so keep them random
  task automatic push_draw();
    cmd_word_t w;
    w.command    = CMD_DRAW;
    w.word_index = ptr_t'($urandom());
    w.word_value = rand_word();
    pending_cmds.push_back(w);
  endtask

  task automatic push_reseed();
    for (int i = 0; i < NUM_WORDS; i++) push_load(ptr_t'(i), rand_word());
    reseeds++;
  endtask

  // Apply one accepted command to the shadow state; a draw yields one expected word
  task automatic advance_generator(input logic command, input ptr_t idx, input word_t value);
    word_t lead;
    word_t trail;
    if (command == CMD_LOAD) begin
      gen_words[idx] = value;
      loads_taken++;
    end else begin
      lead    = gen_words[gen_ptr];
      gen_ptr = gen_ptr + 1'b1;
      trail   = gen_words[gen_ptr];
      trail   = trail ^ (trail << SHIFT_A);
      trail   = trail ^ (trail >> SHIFT_B);
      lead    = lead ^ (lead >> SHIFT_C);
      gen_words[gen_ptr] = lead ^ trail;
      expected_randoms.push_back(gen_words[gen_ptr] * MULT_CONST);
      draws_taken++;
    end
  endtask

  // Sample both handshakes, predict and check
  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      gen_ptr     = '0;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cmd_ch.valid && cmd_ch.ready) begin
        advance_generator(cmd_ch.command, cmd_ch.word_index, cmd_ch.word_value);
        cmd_words_accepted++;
        cmd_taken   = 1'b1;
        idle_cycles = 0;
      end
      if (rnd_ch.valid && rnd_ch.ready) begin
        idle_cycles = 0;
        if (expected_randoms.size() == 0) begin
          $error("random_value: no draw pending, got %h", rnd_ch.random_value);
          fail_count++;
        end else begin
          want = expected_randoms.pop_front();
          randoms_checked++;
          if (rnd_ch.random_value !== want) begin
            $error("random_value: expected %h, got %h", want, rnd_ch.random_value);
            fail_count++;
          end
        end
      end
    end
  end

  // Offer the next command word after a random gap
  always @(negedge clk) begin
    cmd_word_t w;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_taken     = 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        w = pending_cmds.pop_front();
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= w.command;
        cmd_ch.word_index <= w.word_index;
        cmd_ch.word_value <= w.word_value;
        send_gap = pick_gap(calm_stretch);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random; once, hold off long enough to fill the core
  always @(negedge clk) begin
    if (rst) begin
      rnd_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rnd_ch.ready <= 1'b0;
    end else if (!hold_done && cmd_words_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rnd_ch.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      rnd_ch.ready <= 1'b0;
    end else begin
      rnd_ch.ready <= 1'b1;
      ready_gap = pick_gap(calm_stretch);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    @(negedge clk);
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("xorshift1024_star_generator_core regression: fail");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned roll;
    bit          zero_done;

    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_DRAW;
    cmd_ch.word_index  = '0;
    cmd_ch.word_value  = '0;
    rnd_ch.ready       = 1'b0;
    fail_count         = 0;
    idle_cycles        = 0;
    loads_taken        = 0;
    draws_taken        = 0;
    randoms_checked    = 0;
    reseeds            = 0;
    cmd_words_accepted = 0;
    cmd_taken          = 1'b0;
    send_gap           = 0;
    ready_gap          = 0;
    hold_left          = 0;
    hold_done          = 1'b0;
    zero_done          = 1'b0;
    random_items       = 0;

    // Directed: seed with extreme words, draw across them, reload mid-stream
    push_load(4'd0,  '1);
    push_load(4'd1,  '0);
    push_load(4'd2,  64'hAAAA_AAAA_AAAA_AAAA);
    push_load(4'd3,  64'h5555_5555_5555_5555);
    push_load(4'd4,  64'd1);
    push_load(4'd5,  64'h8000_0000_0000_0000);
    push_load(4'd6,  64'h0000_0000_FFFF_FFFF);
    push_load(4'd7,  64'hFFFF_FFFF_0000_0000);
    for (int i = 8; i < NUM_WORDS; i++) push_load(ptr_t'(i), rand_word());
    reseeds++;
    for (int i = 0; i < 4; i++) push_draw();
    push_load(4'd5, '1);
    push_draw();
    push_load(4'd15, '0);
    push_draw();

    // Random: mostly draws, some single loads, occasional full reseed
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (!zero_done && random_items >= RANDOM_ITEMS / 2) begin
        // All-zero state stays at zero; reseed afterwards
        zero_done = 1'b1;
        for (int i = 0; i < NUM_WORDS; i++) push_load(ptr_t'(i), '0);
        for (int i = 0; i < 6; i++) push_draw();
        push_reseed();
        random_items += 2 * NUM_WORDS + 6;
      end else if (roll < 2) begin
        push_reseed();
        random_items += NUM_WORDS;
      end else if (roll < 12) begin
        push_load(ptr_t'($urandom()), rand_word());
        random_items++;
      end else begin
        push_draw();
        random_items++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: all commands taken, all draws answered, then a short tail
    while (pending_cmds.size() != 0 || cmd_ch.valid) @(negedge clk);
    while (expected_randoms.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d loads (%0d full reseeds, one all-zero) and %0d draws",
             loads_taken, reseeds, draws_taken);
    $display("checked %0d random words under random stalls and one long hold-off",
             randoms_checked);
    if (fail_count == 0) begin
      $display("xorshift1024_star_generator_core regression: pass");
    end else begin
      $display("xorshift1024_star_generator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xs1024_pkg.sv
rtl/xs1024_if.sv
rtl/xs1024_front.sv
rtl/xs1024_queue.sv
rtl/xs1024_back.sv
rtl/xorshift1024_star_generator_core.sv
rtl/xs1024_checker.sv
tb/xorshift1024_star_generator_core_tb.sv
